[hw/rtl/dnlc_pkg.sv]
// Shared types and constants for the DNS name label copier.
`timescale 1ns / 1ps
`default_nettype none

package dnlc_pkg;

  // Longest label that a length octet may announce
  localparam logic [7:0] LABEL_MAX = 8'd63;

  // Reset value of the name length limit
  localparam logic [7:0] MAX_NAME_LEN_RST = 8'd255;

  // Parser modes, one-hot
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_LEN   = 3'b010,
    MODE_LABEL = 3'b100
  } parse_mode_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_BUSY   = 3'd0,
    ST_OK     = 3'd1,
    ST_OOB    = 3'd2,
    ST_OVF    = 3'd3,
    ST_BADLEN = 3'd4
  } status_e;

  // One input word
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       name_start;
    logic       message_last;
  } in_item_t;

  // One result word
  typedef struct packed {
    logic [7:0] copy_byte;
    logic       copy_valid;
    logic       name_done;
    status_e    status_code;
    logic [7:0] name_length;
  } out_item_t;

endpackage

`default_nettype wire

[hw/rtl/dnlc_ifs.sv]
// Valid/ready channel interfaces for the input bytes and the parse results.
`timescale 1ns / 1ps
`default_nettype none

interface dnlc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       name_start;
  logic       message_last;

  modport source (output valid, output msg_byte, output name_start, output message_last,
                  input ready);
  modport sink   (input valid, input msg_byte, input name_start, input message_last,
                  output ready);
endinterface

interface dnlc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] copy_byte;
  logic       copy_valid;
  logic       name_done;
  logic [2:0] status_code;
  logic [7:0] name_length;

  modport source (output valid, output copy_byte, output copy_valid, output name_done,
                  output status_code, output name_length, input ready);
  modport sink   (input valid, input copy_byte, input copy_valid, input name_done,
                  input status_code, input name_length, output ready);
endinterface

`default_nettype wire

[hw/rtl/dnlc_in_stage.sv]
// Input register stage: holds one accepted word for the parse stage.
`timescale 1ns / 1ps
`default_nettype none

module dnlc_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire dnlc_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output dnlc_pkg::in_item_t     out_item_o
);
  import dnlc_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  // Free when empty or when the held word moves on this cycle
  assign in_ready_o = !valid_q || out_ready_i;

  // Occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

[hw/rtl/dnlc_parse_stage.sv]
// Parse stage: name walker state, per-byte checks and the result register.
`timescale 1ns / 1ps
`default_nettype none

module dnlc_parse_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               item_valid_i,
  output logic                    item_ready_o,
  input  wire dnlc_pkg::in_item_t item_i,
  input  wire logic [7:0]         max_name_len_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output dnlc_pkg::out_item_t     res_o
);
  import dnlc_pkg::*;

  parse_mode_e mode_q, mode_d, mode_cur;
  logic [5:0]  lab_rem_q, lab_rem_d, lab_rem_cur, lab_dec;
  logic [8:0]  run_len_q, run_len_d, run_len_cur;
  logic [9:0]  sum_hdr, sum_lab, limit;
  logic        res_valid_q;
  out_item_t   res_q, res_d;
  logic        adv;

  // Result register free when empty or being taken
  assign item_ready_o = !res_valid_q || res_ready_i;
  assign adv          = item_valid_i && item_ready_o;

  // A name start restarts the walk with this byte
  assign mode_cur    = item_i.name_start ? MODE_LEN : mode_q;
  assign lab_rem_cur = item_i.name_start ? 6'd0 : lab_rem_q;
  assign run_len_cur = item_i.name_start ? 9'd0 : run_len_q;

  assign sum_hdr = {1'b0, run_len_cur} + 10'd1;
  assign sum_lab = sum_hdr + {2'b00, item_i.msg_byte};
  assign limit   = {2'b00, max_name_len_i};
  assign lab_dec = lab_rem_cur - 6'd1;

  // Per-byte step
  always_comb begin
    mode_d    = mode_cur;
    lab_rem_d = lab_rem_cur;
    run_len_d = run_len_cur;
    res_d     = '{copy_byte: 8'd0, copy_valid: 1'b0, name_done: 1'b0,
                  status_code: ST_BUSY, name_length: 8'd0};
    case (mode_cur)
      MODE_LEN: begin
        if (item_i.msg_byte == 8'd0) begin
          // terminator: success
          mode_d            = MODE_IDLE;
          run_len_d         = sum_hdr[8:0];
          res_d.copy_valid  = 1'b1;
          res_d.name_done   = 1'b1;
          res_d.status_code = ST_OK;
          res_d.name_length = sum_hdr[7:0];
        end else if (item_i.msg_byte > LABEL_MAX) begin
          mode_d            = MODE_IDLE;
          lab_rem_d         = 6'd0;
          res_d.name_done   = 1'b1;
          res_d.status_code = ST_BADLEN;
        end else if (sum_hdr >= limit) begin
          mode_d            = MODE_IDLE;
          lab_rem_d         = 6'd0;
          res_d.name_done   = 1'b1;
          res_d.status_code = ST_OVF;
        end else if (sum_lab >= limit) begin
          mode_d            = MODE_IDLE;
          lab_rem_d         = 6'd0;
          run_len_d         = sum_lab[8:0];
          res_d.name_done   = 1'b1;
          res_d.status_code = ST_OVF;
        end else if (item_i.message_last) begin
          mode_d            = MODE_IDLE;
          lab_rem_d         = 6'd0;
          run_len_d         = sum_lab[8:0];
          res_d.name_done   = 1'b1;
          res_d.status_code = ST_OOB;
        end else begin
          // good length octet: echo it and enter the label
          mode_d           = MODE_LABEL;
          lab_rem_d        = item_i.msg_byte[5:0];
          run_len_d        = sum_lab[8:0];
          res_d.copy_byte  = item_i.msg_byte;
          res_d.copy_valid = 1'b1;
        end
      end
      MODE_LABEL: begin
        if (item_i.message_last) begin
          // terminator can no longer arrive
          mode_d            = MODE_IDLE;
          lab_rem_d         = 6'd0;
          res_d.name_done   = 1'b1;
          res_d.status_code = ST_OOB;
        end else begin
          lab_rem_d        = lab_dec;
          mode_d           = (lab_dec == 6'd0) ? MODE_LEN : MODE_LABEL;
          res_d.copy_byte  = item_i.msg_byte;
          res_d.copy_valid = 1'b1;
        end
      end
      default: begin
        // no name in progress: byte ignored
        mode_d = MODE_IDLE;
      end
    endcase
  end

  // Walker state, updated once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      lab_rem_q <= 6'd0;
      run_len_q <= 9'd0;
    end else if (adv) begin
      mode_q    <= mode_d;
      lab_rem_q <= lab_rem_d;
      run_len_q <= run_len_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (item_ready_o) begin
      res_valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

[hw/rtl/dns_name_label_copier_core.sv]
// Top level of the DNS name label copier: channels, limit register and checks.
//
// Usage: message bytes enter on in_ch, one word per byte, with name_start on the
// first length octet of a name and message_last on the final byte of the message.
// Each accepted word gives exactly one result word on out_ch: the echoed byte with
// copy_valid when it belongs to the name (terminator included), and name_done with
// a status code when the parse ends (success with the total name length, or an
// error). Bytes outside a name give an all-zero result.
// The user writes the name length limit through cfg_we_i / cfg_wdata_i only while
// the block is idle; the block itself does not enforce this. It resets to 255.
// An accepted input word is taken by the input register, and its result word is
// loaded into the parse stage result register when that register is free.
// Throughput: one word per cycle unless out_ch stalls.
// Reset clears both stages and puts the walker in idle. When the receiver stalls,
// the result register holds its word and the input register takes one more word,
// after which in_ch.ready drops until out_ch moves again.
`timescale 1ns / 1ps
`default_nettype none

module dns_name_label_copier_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dnlc_in_if.sink     in_ch,
  dnlc_out_if.source  out_ch,
  input  wire logic   cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i
);
  import dnlc_pkg::*;

  in_item_t   in_item, s1_item;
  out_item_t  res;
  logic       s1_valid, s1_ready;
  logic [7:0] max_len_q;

  // Name length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_NAME_LEN_RST;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  assign in_item.msg_byte     = in_ch.msg_byte;
  assign in_item.name_start   = in_ch.name_start;
  assign in_item.message_last = in_ch.message_last;

  dnlc_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .in_item_i   (in_item),
    .out_valid_o (s1_valid),
    .out_ready_i (s1_ready),
    .out_item_o  (s1_item)
  );

  dnlc_parse_stage u_parse_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (s1_valid),
    .item_ready_o   (s1_ready),
    .item_i         (s1_item),
    .max_name_len_i (max_len_q),
    .res_valid_o    (out_ch.valid),
    .res_ready_i    (out_ch.ready),
    .res_o          (res)
  );

  assign out_ch.copy_byte   = res.copy_byte;
  assign out_ch.copy_valid  = res.copy_valid;
  assign out_ch.name_done   = res.name_done;
  assign out_ch.status_code = res.status_code;
  assign out_ch.name_length = res.name_length;

`ifndef SYNTHESIS
  // Errors never carry a copied byte
  a_copy_not_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.copy_valid) |->
      (out_ch.status_code == ST_BUSY || out_ch.status_code == ST_OK))
    else $error("copy_valid set on an error result");

  // Done flag and a final status go together
  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (out_ch.name_done == (out_ch.status_code != ST_BUSY)))
    else $error("name_done does not match status_code");

  // A length is reported only on success
  a_len_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.name_length != 8'd0) |-> (out_ch.status_code == ST_OK))
    else $error("name_length set without success");

  // Input side backs off only while a result is stalled
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without output back-pressure");
`endif

endmodule

`default_nettype wire

[tb/dns_name_label_copier_core_tb.sv]
// Self-checking testbench for the DNS name label copier core.
`timescale 1ns / 1ps

module dns_name_label_copier_core_tb;
  import dnlc_pkg::*;

  localparam int GAP_MAX     = 16;
  localparam int DRAIN_WAIT  = 4;   // two-stage pipe plus margin
  localparam int TAIL_WAIT   = 8;
  localparam int PHASE_WORDS = 192;
  localparam int N_PHASES    = 6;

  typedef enum bit {ROW_WORD, ROW_LIMIT} row_kind_e;

  // One line of the directed table
  typedef struct {
    row_kind_e  kind;
    logic [7:0] value;     // message byte, or the limit for ROW_LIMIT
    logic       start;
    logic       last;
    bit         fixed;     // expected result typed in below
    out_item_t  res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [7:0] cfg_wdata_i;

  dnlc_in_if  in_ch ();
  dnlc_out_if out_ch ();

  dns_name_label_copier_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predictor state, mirrors the walker
  parse_mode_e walk_mode;
  logic [5:0]  label_left;
  logic [8:0]  name_len;
  logic [7:0]  name_limit;

  out_item_t   pending_results[$];
  stim_row_t   stim_table[$];
  int          words_sent;
  int          mismatches;
  bit          calm;

  // 50 MHz clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic out_item_t res_of(logic [7:0] b, logic v, logic d, status_e s,
                                       logic [7:0] n);
    out_item_t r;
    r.copy_byte   = b;
    r.copy_valid  = v;
    r.name_done   = d;
    r.status_code = s;
    r.name_length = n;
    return r;
  endfunction

  // Next result of the name walker for one word; advances the predictor state
  function automatic out_item_t walk_name_byte(in_item_t w);
    out_item_t r;
    status_e   err;
    bit        failed;
    r      = res_of(8'd0, 1'b0, 1'b0, ST_BUSY, 8'd0);
    err    = ST_BUSY;
    failed = 1'b0;
    if (w.name_start) begin
      walk_mode  = MODE_LEN;
      label_left = '0;
      name_len   = '0;
    end
    case (walk_mode)
      MODE_LEN: begin
        if (w.msg_byte == 8'd0) begin
          name_len  = name_len + 9'd1;
          walk_mode = MODE_IDLE;
          r = res_of(8'd0, 1'b1, 1'b1, ST_OK, name_len[7:0]);
        end else if (w.msg_byte > LABEL_MAX) begin
          failed = 1'b1;
          err    = ST_BADLEN;
        end else if (name_len + 9'd1 >= {1'b0, name_limit}) begin
          failed = 1'b1;
          err    = ST_OVF;
        end else begin
          name_len = name_len + 9'd1 + {1'b0, w.msg_byte};
          if (name_len >= {1'b0, name_limit}) begin
            failed = 1'b1;
            err    = ST_OVF;
          end else if (w.message_last) begin
            failed = 1'b1;
            err    = ST_OOB;
          end else begin
            label_left = w.msg_byte[5:0];
            walk_mode  = MODE_LABEL;
            r = res_of(w.msg_byte, 1'b1, 1'b0, ST_BUSY, 8'd0);
          end
        end
      end
      MODE_LABEL: begin
        if (w.message_last) begin
          failed = 1'b1;
          err    = ST_OOB;
        end else begin
          label_left = label_left - 6'd1;
          if (label_left == 6'd0) walk_mode = MODE_LEN;
          r = res_of(w.msg_byte, 1'b1, 1'b0, ST_BUSY, 8'd0);
        end
      end
      default: begin
        walk_mode = MODE_IDLE;
      end
    endcase
    // any error ends the parse with nothing echoed
    if (failed) begin
      walk_mode  = MODE_IDLE;
      label_left = '0;
      r = res_of(8'd0, 1'b0, 1'b1, err, 8'd0);
    end
    return r;
  endfunction

  // Send one word; called and returns at a falling edge
  task automatic send_word(in_item_t w, bit fixed, out_item_t fixed_res);
    int        gap;
    out_item_t predicted;
    words_sent++;
    gap = calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.msg_byte     <= w.msg_byte;
    in_ch.name_start   <= w.name_start;
    in_ch.message_last <= w.message_last;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = walk_name_byte(w);
    pending_results.push_back(fixed ? fixed_res : predicted);
    @(negedge clk_i);
  endtask

  // Drain the pipe, then write the name length limit
  task automatic set_name_limit(logic [7:0] v);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    name_limit  = v;
  endtask

  function automatic void add_word(logic [7:0] b, logic s, logic l);
    stim_row_t row;
    row = '{ROW_WORD, b, s, l, 1'b0, res_of(8'd0, 1'b0, 1'b0, ST_BUSY, 8'd0)};
    stim_table.push_back(row);
  endfunction

  function automatic void add_checked(logic [7:0] b, logic s, logic l, out_item_t r);
    stim_row_t row;
    row = '{ROW_WORD, b, s, l, 1'b1, r};
    stim_table.push_back(row);
  endfunction

  function automatic void add_limit(logic [7:0] v);
    stim_row_t row;
    row = '{ROW_LIMIT, v, 1'b0, 1'b0, 1'b0, res_of(8'd0, 1'b0, 1'b0, ST_BUSY, 8'd0)};
    stim_table.push_back(row);
  endfunction

  // One random name: mostly well formed, sometimes broken or cut short
  task automatic send_random_name();
    in_item_t  words[$];
    int        len_pos[$];
    in_item_t  w;
    out_item_t unused;
    int        first;
    int        n_labels;
    int        len;
    int        pick;
    int        k;
    unused = res_of(8'd0, 1'b0, 1'b0, ST_BUSY, 8'd0);
    // stray bytes between names
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        w.msg_byte     = 8'($urandom);
        w.name_start   = 1'b0;
        w.message_last = 1'($urandom_range(0, 1));
        words.push_back(w);
      end
    end
    first    = words.size();
    n_labels = $urandom_range(0, 4);
    for (int i = 0; i < n_labels; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 16)      len = $urandom_range(1, 10);
      else if (pick < 19) len = $urandom_range(11, 62);
      else                len = 63;
      len_pos.push_back(words.size());
      w.msg_byte     = 8'(len);
      w.name_start   = 1'b0;
      w.message_last = 1'b0;
      words.push_back(w);
      repeat (len) begin
        w.msg_byte = 8'($urandom);
        words.push_back(w);
      end
    end
    // terminator; message_last on it does no harm
    len_pos.push_back(words.size());
    w.msg_byte     = 8'd0;
    w.name_start   = 1'b0;
    w.message_last = 1'($urandom_range(0, 3) == 0);
    words.push_back(w);
    words[first].name_start = 1'b1;

    // faults
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      k = len_pos[$urandom_range(0, len_pos.size() - 1)];
      words[k].msg_byte = 8'($urandom_range(64, 255));
    end else if (pick < 20) begin
      k = $urandom_range(first, words.size() - 1);
      words[k].message_last = 1'b1;
    end else if (pick < 27 && words.size() > first + 1) begin
      // cut short; the next name start abandons this one
      k = $urandom_range(first + 1, words.size() - 1);
      while (words.size() > k) void'(words.pop_back());
    end

    foreach (words[i]) send_word(words[i], 1'b0, unused);
  endtask

  // Result side: random stalls, compare against the oldest expectation
  initial begin
    int        stall;
    out_item_t exp_res;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, copy_byte %0h status %0d", $time,
                 out_ch.copy_byte, out_ch.status_code);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_ch.copy_byte !== exp_res.copy_byte) begin
          $display("%0t: copy_byte expected %0h actual %0h", $time,
                   exp_res.copy_byte, out_ch.copy_byte);
          mismatches++;
        end
        if (out_ch.copy_valid !== exp_res.copy_valid) begin
          $display("%0t: copy_valid expected %0b actual %0b", $time,
                   exp_res.copy_valid, out_ch.copy_valid);
          mismatches++;
        end
        if (out_ch.name_done !== exp_res.name_done) begin
          $display("%0t: name_done expected %0b actual %0b", $time,
                   exp_res.name_done, out_ch.name_done);
          mismatches++;
        end
        if (out_ch.status_code !== exp_res.status_code) begin
          $display("%0t: status_code expected %0d actual %0d", $time,
                   exp_res.status_code, out_ch.status_code);
          mismatches++;
        end
        if (out_ch.name_length !== exp_res.name_length) begin
          $display("%0t: name_length expected %0d actual %0d", $time,
                   exp_res.name_length, out_ch.name_length);
          mismatches++;
        end
      end
      @(negedge clk_i);
    end
  end

  // Stimulus
  initial begin
    in_item_t w;
    int       phase_end;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = 8'd0;
    in_ch.valid        = 1'b0;
    in_ch.msg_byte     = 8'd0;
    in_ch.name_start   = 1'b0;
    in_ch.message_last = 1'b0;
    walk_mode          = MODE_IDLE;
    label_left         = '0;
    name_len           = '0;
    name_limit         = MAX_NAME_LEN_RST;
    words_sent         = 0;
    mismatches         = 0;
    calm               = 1'b0;

    // Directed table, default limit first
    add_checked(8'h00, 1'b0, 1'b0, res_of(8'd0, 1'b0, 1'b0, ST_BUSY, 8'd0));   // idle
    add_checked(8'hA5, 1'b0, 1'b1, res_of(8'd0, 1'b0, 1'b0, ST_BUSY, 8'd0));
    add_checked(8'h00, 1'b1, 1'b0, res_of(8'd0, 1'b1, 1'b1, ST_OK, 8'd1));     // root
    add_checked(8'd64, 1'b1, 1'b0, res_of(8'd0, 1'b0, 1'b1, ST_BADLEN, 8'd0));
    add_checked(8'hFF, 1'b1, 1'b0, res_of(8'd0, 1'b0, 1'b1, ST_BADLEN, 8'd0));
    add_checked(8'h5A, 1'b0, 1'b0, res_of(8'd0, 1'b0, 1'b0, ST_BUSY, 8'd0));   // after error
    add_word(8'd3, 1'b1, 1'b0);
    add_word(8'h61, 1'b0, 1'b0);
    add_word(8'hFF, 1'b0, 1'b0);
    add_word(8'h00, 1'b0, 1'b0);
    add_checked(8'h00, 1'b0, 1'b0, res_of(8'd0, 1'b1, 1'b1, ST_OK, 8'd5));
    add_word(8'd2, 1'b1, 1'b0);                                                 // restart
    add_word(8'h78, 1'b0, 1'b0);
    add_checked(8'h00, 1'b1, 1'b0, res_of(8'd0, 1'b1, 1'b1, ST_OK, 8'd1));
    add_checked(8'd5, 1'b1, 1'b1, res_of(8'd0, 1'b0, 1'b1, ST_OOB, 8'd0));     // past end
    add_word(8'd2, 1'b1, 1'b0);
    add_word(8'h71, 1'b0, 1'b0);
    add_checked(8'h72, 1'b0, 1'b1, res_of(8'd0, 1'b0, 1'b1, ST_OOB, 8'd0));    // ends in label
    add_checked(8'd63, 1'b1, 1'b1, res_of(8'd0, 1'b0, 1'b1, ST_OOB, 8'd0));
    add_checked(8'h00, 1'b1, 1'b1, res_of(8'd0, 1'b1, 1'b1, ST_OK, 8'd1));
    // limit 1: every label overflows, root still passes
    add_limit(8'd1);
    add_checked(8'd1, 1'b1, 1'b0, res_of(8'd0, 1'b0, 1'b1, ST_OVF, 8'd0));
    add_checked(8'h00, 1'b1, 1'b0, res_of(8'd0, 1'b1, 1'b1, ST_OK, 8'd1));
    // name that just fits, then one that reaches the limit
    add_limit(8'd4);
    add_word(8'd2, 1'b1, 1'b0);
    add_word(8'h00, 1'b0, 1'b0);
    add_word(8'hFF, 1'b0, 1'b0);
    add_checked(8'h00, 1'b0, 1'b0, res_of(8'd0, 1'b1, 1'b1, ST_OK, 8'd4));
    add_checked(8'd3, 1'b1, 1'b0, res_of(8'd0, 1'b0, 1'b1, ST_OVF, 8'd0));

    // reset held, then released at a falling edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_LIMIT) begin
        set_name_limit(stim_table[i].value);
      end else begin
        w.msg_byte     = stim_table[i].value;
        w.name_start   = stim_table[i].start;
        w.message_last = stim_table[i].last;
        send_word(w, stim_table[i].fixed, stim_table[i].res);
      end
    end

    // Random phases over a spread of limits
    phase_end = words_sent;
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       set_name_limit(8'd255);
        1:       set_name_limit(8'd12);
        2:       set_name_limit(8'($urandom_range(2, 254)));
        3:       set_name_limit(8'd1);
        4:       set_name_limit(8'($urandom_range(30, 80)));
        default: set_name_limit(8'd254);
      endcase
      calm = (p == 2);
      phase_end += PHASE_WORDS;
      while (words_sent < phase_end) send_random_name();
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    // Wait for the last results, then report
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/dnlc_pkg.sv
hw/rtl/dnlc_ifs.sv
hw/rtl/dnlc_in_stage.sv
hw/rtl/dnlc_parse_stage.sv
hw/rtl/dns_name_label_copier_core.sv
tb/dns_name_label_copier_core_tb.sv
